// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

// ===== hdl/nct_pkg.sv =====
// Package for the nibble counter table: field widths, codes, FSM state
// and the command/status structs between controller and datapath. No deps.
package nct_pkg;

    localparam int IDX_W            = 12;
    localparam int IDX_SPAN         = 1 << IDX_W;
    localparam int CNT_W            = 4;
    localparam int BYTES_W          = 11;
    localparam int NUM_COUNTERS_DEF = 2048;
    localparam int S_TDATA_W        = 16;
    localparam int M_TDATA_W        = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = 4'hf;
    localparam logic [CNT_W-1:0] CNT_MIN = 4'h0;

    typedef enum logic [1:0] {
        OP_INC   = 2'd0,
        OP_DEC   = 2'd1,
        OP_CHECK = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_OVER  = 2'd2,
        STAT_UNDER = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } state_t;

    typedef struct packed {
        logic accept;   // latch item, issue memory read
        logic exec;     // update counter, load result register
        logic clear;    // one step of the clearing pass
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;   // clearing pass is at its last entry
        logic out_hold;     // result register full and stalled
    } dp_status_t;

endpackage

// ===== hdl/nct_ctrl.sv =====
// Controller FSM for the nibble counter table: clearing pass, accept, execute.
// Depends on nct_pkg.
module nct_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  nct_pkg::dp_status_t    status,
    output nct_pkg::ctrl_cmd_t     cmd
);

    nct_pkg::state_t state_reg;
    nct_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nct_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nct_pkg::S_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = nct_pkg::S_IDLE;
                end
            end
            nct_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = nct_pkg::S_EXEC;
                end
            end
            nct_pkg::S_EXEC:
            begin
                if (!status.out_hold)
                begin
                    state_next = nct_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nct_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.exec   = 1'b0;
        cmd.clear  = 1'b0;
        unique case (state_reg)
            nct_pkg::S_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            nct_pkg::S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            nct_pkg::S_EXEC:
            begin
                cmd.exec = !status.out_hold;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/nct_datapath.sv =====
// Datapath for the nibble counter table: counter memory, clear counter,
// size register, update logic and result register. Depends on nct_pkg.
module nct_datapath #(
    parameter int NUM_COUNTERS = nct_pkg::NUM_COUNTERS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nct_pkg::ctrl_cmd_t           cmd,
    output nct_pkg::dp_status_t          status,
    input  logic [1:0]                   in_command,
    input  logic [nct_pkg::IDX_W-1:0]    in_index,
    input  logic                         cfg_we,
    input  logic [nct_pkg::BYTES_W-1:0]  cfg_wdata,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   out_status,
    output logic                         out_present
);

    // Indices never exceed the port's span, so deeper storage is unreachable.
    localparam int MEM_DEPTH = (NUM_COUNTERS < nct_pkg::IDX_SPAN) ?
                               NUM_COUNTERS : nct_pkg::IDX_SPAN;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [nct_pkg::CNT_W-1:0]   mem [MEM_DEPTH];

    logic [nct_pkg::BYTES_W-1:0] bytes_in_use_reg;
    logic [ADDR_W-1:0]           clr_addr_reg;
    logic [ADDR_W-1:0]           clr_addr_next;
    logic [1:0]                  op_reg;
    logic [nct_pkg::IDX_W-1:0]   idx_reg;
    logic [nct_pkg::CNT_W-1:0]   rd_data_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [1:0]                  status_reg;
    logic                        present_reg;

    logic                        in_range;
    logic                        wr_en;
    logic [nct_pkg::CNT_W-1:0]   wr_data;
    nct_pkg::status_t            res_status;
    logic                        res_present;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_in_use_reg <= '0;
            clr_addr_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bytes_in_use_reg <= cfg_wdata;
            end
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign clr_addr_next  = cmd.clear ? clr_addr_reg + ADDR_W'(1) : clr_addr_reg;
    assign out_valid_next = cmd.exec ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    assign status.clear_last = (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1));
    assign status.out_hold   = out_valid_reg && !out_ready;

    // Range against the configured size and the physical depth.
    assign in_range = (idx_reg < {bytes_in_use_reg, 1'b0}) &&
                      ({1'b0, idx_reg} < (nct_pkg::IDX_W + 1)'(MEM_DEPTH));

    always_comb
    begin
        wr_en       = 1'b0;
        wr_data     = rd_data_reg;
        res_status  = nct_pkg::STAT_OK;
        res_present = 1'b0;
        if (!in_range)
        begin
            res_status = nct_pkg::STAT_RANGE;
        end
        else
        begin
            unique case (op_reg)
                nct_pkg::OP_INC:
                begin
                    if (rd_data_reg == nct_pkg::CNT_MAX)
                    begin
                        res_status = nct_pkg::STAT_OVER;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data_reg + nct_pkg::CNT_W'(1);
                    end
                end
                nct_pkg::OP_DEC:
                begin
                    if (rd_data_reg == nct_pkg::CNT_MIN)
                    begin
                        res_status = nct_pkg::STAT_UNDER;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data_reg - nct_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                    // check, and the unused code acts as a check
                    res_present = (rd_data_reg != nct_pkg::CNT_MIN);
                end
            endcase
        end
    end

    // Memory: one write port (clear or update), one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.exec && wr_en)
        begin
            mem[idx_reg[ADDR_W-1:0]] <= wr_data;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= mem[in_index[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= in_command;
            idx_reg <= in_index;
        end
        if (cmd.exec)
        begin
            status_reg  <= res_status;
            present_reg <= res_present;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = status_reg;
    assign out_present = present_reg;

endmodule

// ===== hdl/nibble_counter_table.sv =====
// Top level of the nibble counter table: controller plus datapath.
// Depends on nct_pkg, nct_ctrl, nct_datapath.
//
// Use:
//   s_* channel carries commands: increment, decrement or check of one 4-bit
//   counter. m_* channel returns one result per item: status and present.
//   cfg_we/cfg_wdata write the bytes-in-use size; write only while idle.
// Timing:
//   After reset a clearing pass zeroes all MEM_DEPTH entries of the counter
//   memory (2048 at the default size), one entry per cycle; s_tready stays low.
//   An accepted item's memory read is registered; its result is loaded into
//   the output register from the execute state. No new item is taken there,
//   due to the registered memory read and write-back on the single write port.
//   The output register lets the next item be accepted while a result waits.
// Stall:
//   If m_tready is low with a result pending, the next item is read but
//   holds in its execute cycle until the output register is free.
module nibble_counter_table #(
    parameter int NUM_COUNTERS = nct_pkg::NUM_COUNTERS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] command, [13:2] counter_index, [15:14] zero
    input  logic [nct_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [2] present, [7:3] zero
    output logic [nct_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [nct_pkg::BYTES_W-1:0]     cfg_wdata
);

    nct_pkg::ctrl_cmd_t  cmd;
    nct_pkg::dp_status_t status;
    logic [1:0]          out_status;
    logic                out_present;

    nct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nct_datapath #(
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_command  (s_tdata[1:0]),
        .in_index    (s_tdata[nct_pkg::IDX_W+1:2]),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (out_status),
        .out_present (out_present)
    );

    assign m_tdata = {(nct_pkg::M_TDATA_W - 3)'(0), out_present, out_status};

endmodule

// ===== hdl/nct_checker.sv =====
// Port-level checker for the nibble counter table, bound to the top level.
// Depends on assert_macros.svh and nct_pkg.
`include "assert_macros.svh"

module nct_port_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [nct_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic s_acc;
    logic m_stall;

    assign s_acc   = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;

    // one item executing at a time: busy right after an accept
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_acc, !s_tready)
    // present only comes with an ok status
    `ASSERT_SAME(a_present_ok, clk, rst_n, m_tvalid && m_tdata[2], m_tdata[1:0] == nct_pkg::STAT_OK)
    `ASSERT_NEXT(a_valid_holds, clk, rst_n, m_stall, m_tvalid)
    `ASSERT_NEXT(a_data_holds, clk, rst_n, m_stall, $stable(m_tdata))

endmodule

bind nibble_counter_table nct_port_checker u_nct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
